/* rtl/assert_macros.svh */
// Assertion macros for the classifier RTL, included by rhc_bin.
// Needs a clock i_clk and an active-low reset i_rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define RHC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rhc assertion failed");

// Consequent holds in the cycle after the antecedent.
`define RHC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rhc assertion failed");

`endif

/* rtl/rhc_pkg.sv */
// Types, constants and helpers for the RGB hue color classifier.
// No dependencies; used by every other RTL file but assert_macros.svh.
`default_nettype none

package rhc_pkg;

    localparam int CH_W        = 8;
    localparam int CLS_W       = 4;
    localparam int SEC_W       = 3;
    localparam int HUE_W       = 17;
    localparam int CFG_IDX_W   = 2;
    localparam int NUM_BOUNDS  = 8;
    localparam int NUM_SECTORS = 6;
    localparam int SECTOR_DEG  = 60;

    typedef enum logic [CLS_W-1:0] {
        CLS_BLACK   = 4'd0,
        CLS_WHITE   = 4'd1,
        CLS_GRAY    = 4'd2,
        CLS_RED     = 4'd3,
        CLS_ORANGE  = 4'd4,
        CLS_YELLOW  = 4'd5,
        CLS_GREEN   = 4'd6,
        CLS_CYAN    = 4'd7,
        CLS_BLUE    = 4'd8,
        CLS_PURPLE  = 4'd9,
        CLS_MAGENTA = 4'd10
    } t_color_class;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DARK_LIMIT  = 2'd0,
        CFG_GRAY_LIMIT  = 2'd1,
        CFG_WHITE_LIMIT = 2'd2
    } t_cfg_idx;

    localparam logic [CH_W-1:0] DARK_LIMIT_RST  = 8'd25;
    localparam logic [CH_W-1:0] GRAY_LIMIT_RST  = 8'd25;
    localparam logic [CH_W-1:0] WHITE_LIMIT_RST = 8'd230;

    localparam logic [8:0] BOUND_DEG [0:NUM_BOUNDS-1] = '{
        9'd15, 9'd45, 9'd70, 9'd150, 9'd190, 9'd260, 9'd320, 9'd345
    };

    localparam t_color_class BOUND_CLS [0:NUM_BOUNDS-1] = '{
        CLS_ORANGE, CLS_YELLOW, CLS_GREEN, CLS_CYAN,
        CLS_BLUE, CLS_PURPLE, CLS_MAGENTA, CLS_RED
    };

    typedef struct packed {
        logic                 achro;
        t_color_class         cls;
        logic [HUE_W-1:0]     hue;
        logic [CH_W-1:0]      spread;
    } t_hue_word;

    function automatic logic [HUE_W-1:0] mul_const(input logic [CH_W-1:0] v,
                                                   input logic [8:0]      k);
        logic [HUE_W-1:0] ve;
        logic [HUE_W-1:0] ke;
        ve = {{(HUE_W-CH_W){1'b0}}, v};
        ke = {{(HUE_W-9){1'b0}}, k};
        return ve * ke;
    endfunction

endpackage

`default_nettype wire

/* rtl/rhc_pixel_if.sv */
// Pixel channel: valid/ready handshake carrying one RGB word.
// Depends on rhc_pkg for the channel width.
`default_nettype none

interface rhc_pixel_if;
    import rhc_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

/* rtl/rhc_class_if.sv */
// Class channel: valid/ready handshake carrying color class and hue sector.
// Depends on rhc_pkg for the field widths.
`default_nettype none

interface rhc_class_if;
    import rhc_pkg::*;

    logic             valid;
    logic             ready;
    logic [CLS_W-1:0] color_class;
    logic [SEC_W-1:0] hue_sector;

    modport source (output valid, output color_class, output hue_sector, input ready);
    modport sink   (input valid, input color_class, input hue_sector, output ready);
endinterface

`default_nettype wire

/* rtl/rhc_hue.sv */
// First stage: max/min, spread, achromatic tests and scaled hue, registered.
// Depends on rhc_pkg and rhc_pixel_if.
`default_nettype none

module rhc_hue (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    rhc_pixel_if.sink                    i_pix,
    input  wire logic [rhc_pkg::CH_W-1:0] i_dark_limit,
    input  wire logic [rhc_pkg::CH_W-1:0] i_gray_limit,
    input  wire logic [rhc_pkg::CH_W-1:0] i_white_limit,
    output rhc_pkg::t_hue_word           o_word,
    output logic                         o_valid,
    input  wire logic                    i_ready
);
    import rhc_pkg::*;

    logic             r_valid;
    t_hue_word        r_word;
    t_hue_word        n_word;
    logic             load;

    logic [CH_W-1:0]  mx;
    logic [CH_W-1:0]  mn;
    logic [CH_W-1:0]  spread;
    logic [CH_W-1:0]  hi;
    logic [CH_W-1:0]  lo;
    logic [CH_W-1:0]  diff;
    logic             plus;
    logic [HUE_W-1:0] base;
    logic [HUE_W-1:0] offs;

    assign i_pix.ready = !r_valid || i_ready;
    assign load        = i_pix.valid && i_pix.ready;

    always_comb begin
        mx = i_pix.red;
        mn = i_pix.red;
        if (i_pix.green > mx) mx = i_pix.green;
        if (i_pix.blue > mx)  mx = i_pix.blue;
        if (i_pix.green < mn) mn = i_pix.green;
        if (i_pix.blue < mn)  mn = i_pix.blue;
        spread = mx - mn;

        if (i_pix.red == mx) begin
            hi = i_pix.green;
            lo = i_pix.blue;
        end else if (i_pix.green == mx) begin
            hi = i_pix.blue;
            lo = i_pix.red;
        end else begin
            hi = i_pix.red;
            lo = i_pix.green;
        end
        plus = hi >= lo;
        diff = plus ? (hi - lo) : (lo - hi);
        offs = mul_const(diff, 9'(SECTOR_DEG));

        if (i_pix.red == mx) begin
            base = plus ? '0 : mul_const(spread, 9'd360);
        end else if (i_pix.green == mx) begin
            base = mul_const(spread, 9'd120);
        end else begin
            base = mul_const(spread, 9'd240);
        end

        n_word.spread = spread;
        n_word.hue    = plus ? (base + offs) : (base - offs);
        if (mx <= i_dark_limit) begin
            n_word.achro = 1'b1;
            n_word.cls   = CLS_BLACK;
        end else if (spread <= i_gray_limit) begin
            n_word.achro = 1'b1;
            n_word.cls   = (mx >= i_white_limit) ? CLS_WHITE : CLS_GRAY;
        end else begin
            n_word.achro = 1'b0;
            n_word.cls   = CLS_RED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_pix.ready) begin
            r_valid <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_word <= n_word;
        end
    end

    assign o_word  = r_word;
    assign o_valid = r_valid;

endmodule

`default_nettype wire

/* rtl/rhc_bin.sv */
// Second stage: bins the scaled hue against boundary*spread, result register.
// Depends on rhc_pkg, rhc_class_if and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module rhc_bin (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire rhc_pkg::t_hue_word i_word,
    input  wire logic               i_valid,
    output logic                    o_ready,
    rhc_class_if.source             o_cls
);
    import rhc_pkg::*;

    logic             r_valid;
    t_color_class     r_cls;
    logic [SEC_W-1:0] r_sector;
    t_color_class     n_cls;
    logic [SEC_W-1:0] n_sector;
    logic             load;

    assign o_ready = !r_valid || o_cls.ready;
    assign load    = i_valid && o_ready;

    always_comb begin
        n_cls    = CLS_RED;
        n_sector = '0;
        for (int i = 0; i < NUM_BOUNDS; i++) begin
            if (i_word.hue >= mul_const(i_word.spread, BOUND_DEG[i])) n_cls = BOUND_CLS[i];
        end
        for (int i = 1; i < NUM_SECTORS; i++) begin
            if (i_word.hue >= mul_const(i_word.spread, 9'(SECTOR_DEG * i))) begin
                n_sector = SEC_W'(i);
            end
        end
        if (i_word.achro) begin
            n_cls    = i_word.cls;
            n_sector = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cls    <= n_cls;
            r_sector <= n_sector;
        end
    end

    assign o_cls.valid       = r_valid;
    assign o_cls.color_class = r_cls;
    assign o_cls.hue_sector  = r_sector;

    `RHC_ASSERT_SAME(a_achro_sector_zero, r_valid && (r_cls == CLS_BLACK || r_cls == CLS_WHITE || r_cls == CLS_GRAY), r_sector == '0)
    `RHC_ASSERT_SAME(a_class_in_range, r_valid, r_cls <= CLS_MAGENTA && r_sector < SEC_W'(NUM_SECTORS))
    `RHC_ASSERT_NEXT(a_chroma_stays_chroma, load && !i_word.achro, r_cls >= CLS_RED)

endmodule

`default_nettype wire

/* rtl/rgb_hue_color_classifier.sv */
// RGB hue color classifier: one pixel word in, one class word out.
// Words are registered in hue stage, then bin stage; 1 word per cycle unless output stalls.
// Hue stage and bin stage each hold one word, so input ready stays high while output flows.
// Reset (synchronous, active low) empties both stages and loads the limits 25, 25, 230.
// Depends on rhc_pkg, rhc_pixel_if, rhc_class_if, rhc_hue and rhc_bin.
`default_nettype none

module rgb_hue_color_classifier (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    rhc_pixel_if.sink                         i_pix,
    rhc_class_if.source                       o_cls,
    input  wire logic                         i_cfg_we,
    input  wire logic [rhc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [rhc_pkg::CH_W-1:0]      i_cfg_data
);
    import rhc_pkg::*;

    logic [CH_W-1:0] r_dark_limit;
    logic [CH_W-1:0] r_gray_limit;
    logic [CH_W-1:0] r_white_limit;

    t_hue_word       hue_word;
    logic            hue_valid;
    logic            bin_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dark_limit  <= DARK_LIMIT_RST;
            r_gray_limit  <= GRAY_LIMIT_RST;
            r_white_limit <= WHITE_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_DARK_LIMIT:  r_dark_limit  <= i_cfg_data;
                CFG_GRAY_LIMIT:  r_gray_limit  <= i_cfg_data;
                CFG_WHITE_LIMIT: r_white_limit <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    rhc_hue u_hue (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pix         (i_pix),
        .i_dark_limit  (r_dark_limit),
        .i_gray_limit  (r_gray_limit),
        .i_white_limit (r_white_limit),
        .o_word        (hue_word),
        .o_valid       (hue_valid),
        .i_ready       (bin_ready)
    );

    rhc_bin u_bin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_word  (hue_word),
        .i_valid (hue_valid),
        .o_ready (bin_ready),
        .o_cls   (o_cls)
    );

endmodule

`default_nettype wire

/* verif/rhc_class_checker.sv */
// Checker for the RGB hue color classifier: watches the pixel, class and limit ports.
// Predicts the class word of every accepted pixel word and compares it in order.
// Depends on rhc_pkg, rhc_pixel_if and rhc_class_if.
module rhc_class_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    rhc_pixel_if                               i_pix,
    rhc_class_if                               i_cls,
    input  wire logic                          i_cfg_we,
    input  wire logic [rhc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [rhc_pkg::CH_W-1:0]      i_cfg_data,
    output int                                 o_fail_count,
    output int                                 o_pending,
    output int                                 o_checked
);
    import rhc_pkg::*;

    typedef struct {
        logic [3*CH_W-1:0] rgb;
        t_color_class      cls;
        logic [SEC_W-1:0]  sector;
    } t_class_word;

    logic [CH_W-1:0] dark_lim;
    logic [CH_W-1:0] gray_lim;
    logic [CH_W-1:0] white_lim;
    t_class_word     expected_classes [$];

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        o_fail_count++;
    endtask

    function automatic t_class_word classify_pixel(input logic [3*CH_W-1:0] rgb);
        int unsigned r;
        int unsigned g;
        int unsigned b;
        int unsigned mx;
        int unsigned mn;
        int unsigned d;
        int unsigned h;
        t_class_word w;
        r = rgb[3*CH_W-1:2*CH_W];
        g = rgb[2*CH_W-1:CH_W];
        b = rgb[CH_W-1:0];
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d = mx - mn;
        w.rgb = rgb;
        w.sector = '0;
        if (mx <= dark_lim) begin
            w.cls = CLS_BLACK;
        end else if (d <= gray_lim) begin
            w.cls = (mx >= white_lim) ? CLS_WHITE : CLS_GRAY;
        end else begin
            // hue scaled by spread, ties go red, then green, then blue
            if (r == mx) begin
                h = (g >= b) ? 60 * (g - b) : 360 * d - 60 * (b - g);
            end else if (g == mx) begin
                h = (b >= r) ? 120 * d + 60 * (b - r) : 120 * d - 60 * (r - b);
            end else begin
                h = (r >= g) ? 240 * d + 60 * (r - g) : 240 * d - 60 * (g - r);
            end
            if (h < 15 * d)       w.cls = CLS_RED;
            else if (h < 45 * d)  w.cls = CLS_ORANGE;
            else if (h < 70 * d)  w.cls = CLS_YELLOW;
            else if (h < 150 * d) w.cls = CLS_GREEN;
            else if (h < 190 * d) w.cls = CLS_CYAN;
            else if (h < 260 * d) w.cls = CLS_BLUE;
            else if (h < 320 * d) w.cls = CLS_PURPLE;
            else if (h < 345 * d) w.cls = CLS_MAGENTA;
            else                  w.cls = CLS_RED;
            w.sector = SEC_W'(h / (60 * d));
        end
        return w;
    endfunction

    always @(posedge i_clk) begin
        t_class_word want;
        if (!i_rst_n) begin
            expected_classes.delete();
            dark_lim  = DARK_LIMIT_RST;
            gray_lim  = GRAY_LIMIT_RST;
            white_lim = WHITE_LIMIT_RST;
        end else begin
            if (i_cls.valid && i_cls.ready) begin
                if (expected_classes.size() == 0) begin
                    report_mismatch($sformatf("class word %0d/%0d with no pixel pending",
                                              i_cls.color_class, i_cls.hue_sector));
                end else begin
                    want = expected_classes.pop_front();
                    o_checked++;
                    if (i_cls.color_class !== want.cls)
                        report_mismatch($sformatf("pixel %06h color_class %0d, want %0d (%s)",
                                                  want.rgb, i_cls.color_class, want.cls,
                                                  want.cls.name()));
                    if (i_cls.hue_sector !== want.sector)
                        report_mismatch($sformatf("pixel %06h hue_sector %0d, want %0d",
                                                  want.rgb, i_cls.hue_sector, want.sector));
                end
            end
            if (i_pix.valid && i_pix.ready)
                expected_classes.push_back(classify_pixel({i_pix.red, i_pix.green, i_pix.blue}));
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DARK_LIMIT:  dark_lim  = i_cfg_data;
                    CFG_GRAY_LIMIT:  gray_lim  = i_cfg_data;
                    CFG_WHITE_LIMIT: white_lim = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending = expected_classes.size();
    end

endmodule

/* verif/tb.sv */
// Testbench top for the RGB hue color classifier: clock, reset, pixel and limit stimulus.
// Instantiates the block and rhc_class_checker, and gives the verdict from its counts.
// Depends on rhc_pkg, rhc_pixel_if, rhc_class_if and rhc_class_checker.
module tb;
    import rhc_pkg::*;

    localparam int NUM_PHASES      = 9;
    localparam int WORDS_PER_PHASE = 205;
    localparam int HOLD_CYCLES     = 300;
    localparam int SETTLE_CYCLES   = 4;
    localparam int CYCLE_LIMIT     = 500000;
    localparam int NUM_DIRECTED    = 26;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    typedef enum int {
        MODE_SLOW_SINK,
        MODE_SLOW_SOURCE,
        MODE_FULL_RATE
    } t_idle_mode;

    localparam logic [3*CH_W-1:0] DIRECTED_PIXELS [NUM_DIRECTED] = '{
        24'h000000, 24'hFFFFFF, 24'h808080, 24'h191919, 24'h1A1A1A, 24'hE6E6E6,
        24'hE5E5E5, 24'h644B4B, 24'h644A4A, 24'hFF0000, 24'hFF000A, 24'hFF003C,
        24'hFF0064, 24'hF03C00, 24'hF0B400, 24'hF0F000, 24'hC8F000, 24'h00F000,
        24'h00F078, 24'h00F0F0, 24'h00C8F0, 24'h0000F0, 24'h5000F0, 24'hF000F0,
        24'hF000A0, 24'hF0003C
    };

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CH_W-1:0] cfg_data;

    int tx_idle_pct;
    int rx_idle_pct;
    int hold_requests;
    int words_sent;
    int settings_loaded;
    int cycles;
    int fail_count;
    int pending;
    int checked;

    rhc_pixel_if pix();
    rhc_class_if cls();

    rgb_hue_color_classifier u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (pix),
        .o_cls      (cls),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    rhc_class_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pix        (pix),
        .i_cls        (cls),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TIMEOUT after %0d cycles, %0d class words outstanding", cycles, pending);
            $display("tb NOT OK");
            $finish;
        end
    end

    function automatic bit idles(input int pct);
        return $urandom_range(99) < pct;
    endfunction

    function automatic logic [CH_W-1:0] jitter(input int base);
        int v;
        v = base + $urandom_range(60) - 30;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return CH_W'(v);
    endfunction

    function automatic logic [CH_W-1:0] rail_or_any();
        case ($urandom_range(2))
            0: return '0;
            1: return '1;
            default: return CH_W'($urandom);
        endcase
    endfunction

    function automatic logic [3*CH_W-1:0] random_pixel();
        int k;
        int base;
        logic [CH_W-1:0] lo;
        logic [CH_W-1:0] mid;
        logic [CH_W-1:0] hi;
        case ($urandom_range(5))
            0, 1: return 24'($urandom);
            2: begin
                base = $urandom_range(255);
                return {jitter(base), jitter(base), jitter(base)};
            end
            3: return {CH_W'($urandom_range(40)), CH_W'($urandom_range(40)),
                       CH_W'($urandom_range(40))};
            4: return {rail_or_any(), rail_or_any(), rail_or_any()};
            default: begin
                // hue on a 5-degree grid: spread a multiple of 12
                k   = $urandom_range(21, 1);
                lo  = CH_W'($urandom_range(255 - 12 * k));
                mid = CH_W'(lo + $urandom_range(12) * k);
                hi  = CH_W'(lo + 12 * k);
                case ($urandom_range(5))
                    0: return {hi, mid, lo};
                    1: return {mid, hi, lo};
                    2: return {lo, hi, mid};
                    3: return {lo, mid, hi};
                    4: return {mid, lo, hi};
                    default: return {hi, lo, mid};
                endcase
            end
        endcase
    endfunction

    task automatic set_idle_mode(input t_idle_mode mode);
        case (mode)
            MODE_SLOW_SINK: begin
                tx_idle_pct <= 10;
                rx_idle_pct <= 81;
            end
            MODE_SLOW_SOURCE: begin
                tx_idle_pct <= 81;
                rx_idle_pct <= 10;
            end
            default: begin
                tx_idle_pct <= 0;
                rx_idle_pct <= 0;
            end
        endcase
    endtask

    task automatic send_pixel(input logic [3*CH_W-1:0] rgb);
        while (idles(tx_idle_pct)) begin
            pix.valid <= 1'b0;
            @(negedge i_clk);
        end
        pix.valid <= 1'b1;
        {pix.red, pix.green, pix.blue} <= rgb;
        @(posedge i_clk);
        while (!pix.ready) @(posedge i_clk);
        @(negedge i_clk);
        words_sent++;
    endtask

    task automatic drain();
        pix.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic load_limits(input logic [CH_W-1:0] dark, input logic [CH_W-1:0] gray,
                               input logic [CH_W-1:0] white);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_DARK_LIMIT;
        cfg_data <= dark;
        @(negedge i_clk);
        cfg_idx  <= CFG_GRAY_LIMIT;
        cfg_data <= gray;
        @(negedge i_clk);
        cfg_idx  <= CFG_WHITE_LIMIT;
        cfg_data <= white;
        @(negedge i_clk);
        cfg_idx  <= CFG_UNUSED_IDX;
        cfg_data <= CH_W'($urandom);
        @(negedge i_clk);
        cfg_we <= 1'b0;
        settings_loaded++;
    endtask

    initial begin : receiver
        int hold_left;
        int holds_taken;
        hold_left   = 0;
        holds_taken = 0;
        cls.ready   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left == 0 && holds_taken != hold_requests) begin
                holds_taken = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                cls.ready <= 1'b0;
            end else begin
                cls.ready <= !idles(rx_idle_pct);
            end
        end
    end

    initial begin : stimulus
        i_rst_n         = 1'b0;
        pix.valid       = 1'b0;
        pix.red         = '0;
        pix.green       = '0;
        pix.blue        = '0;
        cfg_we          = 1'b0;
        cfg_idx         = CFG_DARK_LIMIT;
        cfg_data        = '0;
        tx_idle_pct     = 0;
        rx_idle_pct     = 0;
        hold_requests   = 0;
        words_sent      = 0;
        settings_loaded = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        set_idle_mode(MODE_SLOW_SINK);
        @(negedge i_clk);

        for (int i = 0; i < NUM_DIRECTED; i++)
            send_pixel(DIRECTED_PIXELS[i]);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            drain();
            case (phase)
                0: load_limits(DARK_LIMIT_RST, GRAY_LIMIT_RST, WHITE_LIMIT_RST);
                1: load_limits(8'd0, 8'd0, 8'd0);
                2: load_limits(8'd255, 8'd255, 8'd255);
                3: load_limits(8'd0, 8'd255, 8'd0);
                4: load_limits(8'd255, 8'd0, 8'd255);
                5: load_limits(8'd10, 8'd40, 8'd200);
                default: load_limits(CH_W'($urandom_range(60)), CH_W'($urandom_range(80)),
                                     CH_W'($urandom));
            endcase
            set_idle_mode(t_idle_mode'(phase * 3 / NUM_PHASES));
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                if (n == 50 && (phase == 4 || phase == 6))
                    hold_requests <= hold_requests + 1;
                if (n == 100 && phase == 7)
                    drain();
                send_pixel(random_pixel());
            end
        end
        drain();

        $display("Summary: %0d pixel words sent, %0d class words checked, %0d limit settings",
                 words_sent, checked, settings_loaded);
        $display("Summary: sink held off %0d times for %0d cycles, source drained mid-stream",
                 hold_requests, HOLD_CYCLES);
        if (fail_count == 0 && pending == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
